// File: rtl/core/dqz_pkg.sv
// dqz_pkg: widths and constants for the int4 zero-point bf16 dequantizer
// no dependencies
`default_nettype none
package dqz_pkg;
  localparam int unsigned ByteW = 8;
  localparam int unsigned Bf16W = 16;
  localparam int unsigned Fp32W = 32;
  localparam int unsigned NibbleW = 4;
  // bf16 pattern of 100.0, the largest magnitude kept
  localparam logic [Bf16W-2:0] LimitMag = 15'h42C8;
  localparam logic [7:0] ExpAllOnes = 8'hFF;
  localparam logic [3:0] NibbleMask = 4'hF;
  localparam logic [Fp32W-1:0] RoundBias = 32'h0000_7FFF;
  // zero point exponent whose lsb lands on 2^-30
  localparam logic [7:0] AlignExp = 8'd104;
  typedef logic [Bf16W-1:0] bf16_t;
  typedef logic [Fp32W-1:0] fp32_t;
endpackage
`default_nettype wire

// File: rtl/core/dqz_chan_if.sv
// dqz_in_if / dqz_out_if: valid-ready channels of the dequantizer
// depends on dqz_pkg
`default_nettype none
interface dqz_in_if import dqz_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  packed_byte;
  logic              high_nibble;
  bf16_t             scale_bf16;
  bf16_t             zero_point_bf16;
  modport source (output valid, packed_byte, high_nibble, scale_bf16, zero_point_bf16,
                  input ready);
  modport sink (input valid, packed_byte, high_nibble, scale_bf16, zero_point_bf16,
                output ready);
endinterface

interface dqz_out_if import dqz_pkg::*; ();
  logic  valid;
  logic  ready;
  bf16_t weight_bf16;
  modport source (output valid, weight_bf16, input ready);
  modport sink (input valid, weight_bf16, output ready);
endinterface
`default_nettype wire

// File: rtl/core/int4_zero_point_dequant_bf16.sv
// int4_zero_point_dequant_bf16: (q - zp) * scale in fp32, rounded to bf16
// throughput one transaction per cycle while the output is not stalled; six register stages
// (align, subtract, normalize, multiply, count zeros, round) each move when free
// a stall at the output holds the stages; empty stages still fill behind it
// reset (synchronous, rst_n low) clears the stage valid bits only
// depends on dqz_pkg and dqz_chan_if
`default_nettype none
module int4_zero_point_dequant_bf16 import dqz_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  dqz_in_if.sink    in_ch,
  dqz_out_if.source out_ch
);
  localparam int unsigned NStage = 6;

  logic [NStage-1:0] v_r;
  logic [NStage-1:0] en;

  always_comb begin
    en[NStage-1] = !v_r[NStage-1] || out_ch.ready;
    for (int i = NStage-2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_ch.valid;
      for (int i = 1; i < NStage; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  function automatic logic [5:0] clz39(input logic [38:0] x);
    logic [5:0] n;
    n = 6'd39;
    for (int i = 0; i < 39; i++) begin
      if (x[i]) n = 6'(38 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] clz32(input logic [31:0] x);
    logic [4:0] n;
    n = 5'd31;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = 5'(31 - i);
    end
    return n;
  endfunction

  function automatic bf16_t sanitize(input bf16_t x);
    if (x[14:7] == ExpAllOnes || x[14:0] > LimitMag) return '0;
    return x;
  endfunction

  // ---------------- stage 1: nibble pick, sanitize, align zp to 2^-30
  bf16_t       zsan, ssan;
  logic [7:0]  ze_eff;
  logic [7:0]  zm;
  logic [7:0]  rsh;
  logic [36:0] zal;
  logic        zst;
  logic [3:0]  q_sel;

  always_comb begin
    zsan   = sanitize(in_ch.zero_point_bf16);
    ssan   = sanitize(in_ch.scale_bf16);
    ze_eff = (zsan[14:7] == 8'd0) ? 8'd1 : zsan[14:7];
    zm     = {zsan[14:7] != 8'd0, zsan[6:0]};
    q_sel  = in_ch.high_nibble ? (in_ch.packed_byte[7:4] & NibbleMask)
                               : (in_ch.packed_byte[3:0] & NibbleMask);
    rsh    = AlignExp - ze_eff;
    zal    = '0;
    zst    = 1'b0;
    if (ze_eff >= AlignExp) begin
      zal = 37'(zm) << (ze_eff - AlignExp);
    end else if (rsh >= 8'd8) begin
      zst = |zm;
    end else begin
      zal = 37'(zm >> rsh[2:0]);
      zst = ((zm >> rsh[2:0]) << rsh[2:0]) != zm;
    end
  end

  logic [3:0]  q1_r;
  logic [36:0] zal1_r;
  logic        zst1_r;
  bf16_t       z1_r, s1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q1_r   <= q_sel;
      zal1_r <= zal;
      zst1_r <= zst;
      z1_r   <= zsan;
      s1_r   <= ssan;
    end
  end

  // ---------------- stage 2: fixed point subtract at 2^-31, sticky in bit 0
  logic [38:0] qf, zf, dmag_nxt;
  logic        dsgn_nxt;
  fp32_t       dq0_nxt;

  always_comb begin
    qf = 39'(q1_r) << 31;
    zf = {1'b0, zal1_r, zst1_r};
    if (z1_r[15]) begin
      dmag_nxt = qf + zf;
      dsgn_nxt = 1'b0;
    end else if (qf >= zf) begin
      dmag_nxt = qf - zf;
      dsgn_nxt = 1'b0;
    end else begin
      dmag_nxt = zf - qf;
      dsgn_nxt = 1'b1;
    end
    // q of zero gives -zp exactly, but zero minus a zero is +0
    dq0_nxt = (z1_r[14:0] == 15'd0) ? '0 : {~z1_r[15], z1_r[14:0], 16'd0};
  end

  logic [38:0] dmag2_r;
  logic        dsgn2_r, qz2_r;
  fp32_t       dq0_2_r;
  bf16_t       s2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dmag2_r <= dmag_nxt;
      dsgn2_r <= dsgn_nxt;
      qz2_r   <= (q1_r == 4'd0);
      dq0_2_r <= dq0_nxt;
      s2_r    <= s1_r;
    end
  end

  // ---------------- stage 3: normalize and round the difference to fp32
  logic [5:0]  dlz;
  logic [38:0] dnorm;
  logic [24:0] dm;
  logic        dround;
  logic [7:0]  dexp;
  fp32_t       diff_nxt;

  always_comb begin
    dlz    = clz39(dmag2_r);
    dnorm  = dmag2_r << dlz;
    dround = dnorm[14] && ((|dnorm[13:0]) || dnorm[15]);
    dm     = 25'(dnorm[38:15]) + 25'(dround);
    // leading one at bit 38-dlz weighs 2^(7-dlz), biased exponent 134-dlz
    dexp   = 8'd133 - 8'(dlz);
    if (qz2_r) begin
      diff_nxt = dq0_2_r;
    end else if (dmag2_r == '0) begin
      diff_nxt = '0;
    end else begin
      diff_nxt = {dsgn2_r, 31'd0} | ((32'(dexp) << 23) + 32'(dm));
    end
  end

  fp32_t diff3_r;
  bf16_t s3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      diff3_r <= diff_nxt;
      s3_r    <= s2_r;
    end
  end

  // ---------------- stage 4: mantissa product
  logic [23:0] md;
  logic [7:0]  ms;
  logic [7:0]  ed_eff, es_eff;

  always_comb begin
    md     = {diff3_r[30:23] != 8'd0, diff3_r[22:0]};
    ms     = {s3_r[14:7] != 8'd0, s3_r[6:0]};
    ed_eff = (diff3_r[30:23] == 8'd0) ? 8'd1 : diff3_r[30:23];
    es_eff = (s3_r[14:7] == 8'd0) ? 8'd1 : s3_r[14:7];
  end

  logic [31:0] p4_r;
  logic [8:0]  esum4_r;
  logic        sg4_r, zr4_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      p4_r    <= 32'(md) * 32'(ms);
      esum4_r <= 9'(ed_eff) + 9'(es_eff);
      sg4_r   <= diff3_r[31] ^ s3_r[15];
      zr4_r   <= (md == 24'd0) || (ms == 8'd0);
    end
  end

  // ---------------- stage 5: product leading zeros, exponent and denormal shift
  logic [4:0]        plz;
  logic signed [10:0] pbias;
  logic [7:0]        expf_nxt;
  logic [4:0]        ext_nxt;
  logic signed [10:0] need;

  always_comb begin
    plz   = clz32(p4_r);
    pbias = $signed({2'b00, esum4_r}) - 11'sd126 - $signed({6'd0, plz});
    need  = 11'sd1 - pbias;
    if (pbias >= 11'sd1) begin
      expf_nxt = 8'(pbias - 11'sd1);
      ext_nxt  = 5'd0;
    end else begin
      expf_nxt = 8'd0;
      ext_nxt  = (need > 11'sd26) ? 5'd26 : 5'(need);
    end
  end

  logic [31:0] pn5_r;
  logic [7:0]  expf5_r;
  logic [4:0]  ext5_r;
  logic        sg5_r, zr5_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      pn5_r   <= p4_r << plz;
      expf5_r <= expf_nxt;
      ext5_r  <= ext_nxt;
      sg5_r   <= sg4_r;
      zr5_r   <= zr4_r;
    end
  end

  // ---------------- stage 6: round product to fp32, then fp32 to bf16
  logic [63:0] pw;
  logic [24:0] pm;
  logic        pround;
  fp32_t       w32, wsum;

  always_comb begin
    pw     = {pn5_r, 32'd0} >> (6'd8 + 6'(ext5_r));
    pround = pw[31] && ((|pw[30:0]) || pw[32]);
    pm     = 25'(pw[55:32]) + 25'(pround);
    if (zr5_r) begin
      w32 = {sg5_r, 31'd0};
    end else begin
      w32 = {sg5_r, 31'd0} | ((32'(expf5_r) << 23) + 32'(pm));
    end
    wsum = w32 + RoundBias + 32'(w32[16]);
  end

  bf16_t w6_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      w6_r <= wsum[31:16];
    end
  end

  assign out_ch.valid       = v_r[NStage-1];
  assign out_ch.weight_bf16 = w6_r;

  // input only blocks when every stage holds a transaction
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> &v_r) else $error("input stalled with an empty stage");

  // |w| <= 11500 keeps the exponent at or below 2^14
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.weight_bf16[14:7] <= 8'd141)
    else $error("weight exponent out of range");

  // sanitized scale never exceeds 100
  a_scale_clean: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> s1_r[14:0] <= LimitMag) else $error("scale not sanitized");

  // a stalled output stage keeps its transaction and the stage before it
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[5] && !out_ch.ready && v_r[4] |=> v_r[5] && v_r[4])
    else $error("stage lost under stall");
endmodule
`default_nettype wire

// File: tb/tb.sv
// tb: self-checking testbench for int4_zero_point_dequant_bf16
// computes each expected bf16 weight with exact integer float arithmetic
// depends on dqz_pkg, dqz_chan_if and the dequantizer rtl
`default_nettype none
module tb;
  import dqz_pkg::*;

  typedef struct {
    logic [ByteW-1:0] packed_byte;
    logic             high_nibble;
    bf16_t            scale;
    bf16_t            zero_point;
  } dq_item_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 20;

  logic clk;
  logic rst_n;
  dqz_in_if  in_ch();
  dqz_out_if out_ch();

  int4_zero_point_dequant_bf16 uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  dq_item_t pending_items[$];
  bf16_t    weight_expected[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_gap = 0;
  int unsigned sink_stall = 0;
  logic in_taken = 1'b0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // round sign * mag * 2^e to fp32, nearest even, with subnormals
  function automatic fp32_t round_fp32(logic sign, logic [191:0] mag, int e);
    int msb;
    int shift;
    int ue;
    logic [191:0] kept;
    logic [191:0] rem;
    logic [191:0] half;
    logic subn;
    msb = -1;
    for (int i = 0; i < 192; i++) if (mag[i]) msb = i;
    if (msb < 0) return {sign, 31'd0};
    ue = msb + e;
    subn = (ue < -126);
    shift = subn ? (-149 - e) : (msb - 23);
    if (shift > 190) return {sign, 31'd0};
    if (shift > 0) begin
      kept = mag >> shift;
      rem = mag & ((192'd1 << shift) - 1);
      half = 192'd1 << (shift - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 1;
    end else begin
      kept = mag << (-shift);
    end
    if (subn) return {sign, 7'd0, kept[23], kept[22:0]};
    if (kept[24]) begin
      kept = kept >> 1;
      ue = ue + 1;
    end
    return {sign, 8'(ue + 127), kept[22:0]};
  endfunction

  // out-of-range or non-finite group parameters count as +0
  function automatic bf16_t clean_param(bf16_t raw);
    if (raw[14:7] == ExpAllOnes || raw[14:0] > LimitMag) return '0;
    return raw;
  endfunction

  function automatic bf16_t dequant_weight(dq_item_t it);
    bf16_t sc;
    bf16_t zp;
    logic [NibbleW-1:0] q;
    logic signed [191:0] diff;
    logic signed [191:0] zp_term;
    logic [191:0] mag;
    fp32_t d;
    fp32_t w;
    logic [23:0] d_mag;
    logic [7:0] s_mag;
    int d_e;
    int s_e;
    int zp_e;
    q = it.high_nibble ? (it.packed_byte[7:4] & NibbleMask) : (it.packed_byte[3:0] & NibbleMask);
    sc = clean_param(it.scale);
    zp = clean_param(it.zero_point);
    // difference on a 2^-133 grid is exact
    zp_e = (zp[14:7] == 0) ? 0 : int'(zp[14:7]) - 1;
    zp_term = 192'({zp[14:7] != 0, zp[6:0]}) << zp_e;
    if (zp[15]) zp_term = -zp_term;
    diff = (192'(q) << 133) - zp_term;
    mag = diff[191] ? -diff : diff;
    // an exact zero difference is +0 here
    d = round_fp32(diff[191], mag, -133);
    d_mag = {d[30:23] != 0, d[22:0]};
    d_e = (d[30:23] == 0) ? -149 : int'(d[30:23]) - 150;
    s_mag = {sc[14:7] != 0, sc[6:0]};
    s_e = (sc[14:7] == 0) ? -133 : int'(sc[14:7]) - 134;
    w = round_fp32(d[31] ^ sc[15], 192'(d_mag) * 192'(s_mag), d_e + s_e);
    w = w + RoundBias + fp32_t'(w[16]);
    return w[31:16];
  endfunction

  function automatic bf16_t rand_param();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return bf16_t'($urandom());
    if (r < 45) return {1'($urandom()), ExpAllOnes, 7'($urandom())};
    return {1'($urandom()), 8'($urandom_range(100, 133)), 7'($urandom())};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_item(logic [7:0] b, logic hi, bf16_t sc, bf16_t zp);
    dq_item_t it;
    it.packed_byte = b;
    it.high_nibble = hi;
    it.scale = sc;
    it.zero_point = zp;
    pending_items.push_back(it);
  endtask

  // expectation on input transaction, check on output transaction
  always @(posedge clk) begin
    bf16_t exp_w;
    dq_item_t it;
    cycles <= cycles + 1;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it.packed_byte = in_ch.packed_byte;
      it.high_nibble = in_ch.high_nibble;
      it.scale = in_ch.scale_bf16;
      it.zero_point = in_ch.zero_point_bf16;
      weight_expected.push_back(dequant_weight(it));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (weight_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected weight %h", out_ch.weight_bf16);
      end else begin
        exp_w = weight_expected.pop_front();
        if (out_ch.weight_bf16 !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("weight mismatch: expected %h got %h", exp_w, out_ch.weight_bf16);
        end
      end
    end
  end

  // driver and receiver stalls
  always @(negedge clk) begin
    logic nv;
    dq_item_t it;
    if (rst_n) begin
      nv = in_ch.valid && !in_taken;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_ch.packed_byte <= it.packed_byte;
          in_ch.high_nibble <= it.high_nibble;
          in_ch.scale_bf16 <= it.scale;
          in_ch.zero_point_bf16 <= it.zero_point;
          nv = 1'b1;
          send_gap = pick_gap();
        end
      end
      in_ch.valid <= nv;
      if (sink_stall > 0) begin
        sink_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        sink_stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("int4_zero_point_dequant_bf16 test failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.packed_byte = '0;
    in_ch.high_nibble = 1'b0;
    in_ch.scale_bf16 = '0;
    in_ch.zero_point_bf16 = '0;
    out_ch.ready = 1'b0;

    // field extremes and nibble select
    add_item(8'h00, 1'b0, 16'h3F80, 16'h0000);
    add_item(8'hFF, 1'b1, 16'h3F80, 16'h0000);
    add_item(8'hF0, 1'b0, 16'h42C8, 16'h42C8);
    add_item(8'hF0, 1'b1, 16'hC2C8, 16'hC2C8);
    add_item(8'h0F, 1'b1, 16'hFFFF, 16'hFFFF);
    // non-finite scale and zero point
    add_item(8'h37, 1'b0, 16'h7F80, 16'h3F80);
    add_item(8'h37, 1'b1, 16'hFF80, 16'h7FC1);
    add_item(8'h5A, 1'b0, 16'h3E00, 16'h7F80);
    add_item(8'h5A, 1'b1, 16'h3E00, 16'hFFC0);
    // just above the magnitude limit
    add_item(8'h9C, 1'b0, 16'h42C9, 16'h4000);
    add_item(8'h9C, 1'b1, 16'h3F00, 16'hC2C9);
    // negative zero result and zero operands
    add_item(8'h10, 1'b0, 16'hBF80, 16'h0000);
    add_item(8'h10, 1'b0, 16'hBF80, 16'h8000);
    add_item(8'h01, 1'b0, 16'h8000, 16'h4000);
    // subnormal operands and deep cancellation
    add_item(8'h0F, 1'b0, 16'h0001, 16'h0001);
    add_item(8'h00, 1'b0, 16'h007F, 16'h8001);
    add_item(8'h03, 1'b0, 16'h0080, 16'h4040);
    add_item(8'h0F, 1'b0, 16'h3C01, 16'h4171);
    add_item(8'hE0, 1'b1, 16'h0100, 16'h0200);
    add_item(8'h07, 1'b0, 16'h42C7, 16'hC2C7);
    add_item(8'h80, 1'b1, 16'h3B80, 16'h40FF);

    for (int i = 0; i < 1800; i++)
      add_item(8'($urandom()), 1'($urandom()), rand_param(), rand_param());

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() > 0 || in_ch.valid || weight_expected.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && weight_expected.size() == 0) begin
      $display("int4_zero_point_dequant_bf16 test passed");
    end else begin
      $display("int4_zero_point_dequant_bf16 test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
